>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frustum cull block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AFCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define AFCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/afcd_pkg.sv
// ----------------------------------------------------------------------------
// afcd_pkg
// Widths, register indexes and shared types of the frustum cull block.
// ----------------------------------------------------------------------------
package afcd_pkg;

   localparam int COORD_BITS = 24;
   localparam int COEF_BITS  = 16;
   localparam int CAM_BITS   = 24;
   localparam int HANDLE_W   = 32;
   localparam int SLOT_W     = 16;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int PROD_W     = COEF_BITS + COORD_BITS;
   localparam int CLIP_W     = PROD_W + 2;
   localparam int CMP_W      = CLIP_W + 1;
   localparam int DELTA_W    = COORD_BITS + 2;
   localparam int SQ_W       = 2 * DELTA_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int DIST_W     = 52;

   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_COL0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_COL1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_COL2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_COL3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_XY      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_Z       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CULL_ENABLE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INVALID_HANDLES = 3'd7;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef coord_type [2:0]              vec3_type;
   typedef coef_type [3:0][3:0]          coef_mat_type;   // [row][col]

   typedef struct packed {
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

>>> sv/afcd_req_if.sv
// ----------------------------------------------------------------------------
// afcd_req_if
// Input item channel: valid/ready handshake with the item payload.
// ----------------------------------------------------------------------------
interface afcd_req_if;
   import afcd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            item_flags;
   logic [HANDLE_W-1:0]   mesh_id;
   logic [HANDLE_W-1:0]   material_id;
   logic signed [COORD_BITS-1:0] box_min_x;
   logic signed [COORD_BITS-1:0] box_min_y;
   logic signed [COORD_BITS-1:0] box_min_z;
   logic signed [COORD_BITS-1:0] box_max_x;
   logic signed [COORD_BITS-1:0] box_max_y;
   logic signed [COORD_BITS-1:0] box_max_z;
   logic signed [COORD_BITS-1:0] origin_x;
   logic signed [COORD_BITS-1:0] origin_y;
   logic signed [COORD_BITS-1:0] origin_z;

   modport source (output valid, item_flags, mesh_id, material_id, box_min_x, box_min_y,
                   box_min_z, box_max_x, box_max_y, box_max_z, origin_x, origin_y, origin_z,
                   input ready);
   modport sink (input valid, item_flags, mesh_id, material_id, box_min_x, box_min_y,
                 box_min_z, box_max_x, box_max_y, box_max_z, origin_x, origin_y, origin_z,
                 output ready);
endinterface

>>> sv/afcd_rsp_if.sv
// ----------------------------------------------------------------------------
// afcd_rsp_if
// Result channel: valid/ready handshake with the kept item payload.
// ----------------------------------------------------------------------------
interface afcd_rsp_if;
   import afcd_pkg::*;
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] kept_mesh_id;
   logic [HANDLE_W-1:0] kept_material_id;
   logic [DIST_W-1:0]   distance_sq;

   modport source (output valid, kept_mesh_id, kept_material_id, distance_sq, input ready);
   modport sink (input valid, kept_mesh_id, kept_material_id, distance_sq, output ready);
endinterface

>>> sv/afcd_clip.sv
// ----------------------------------------------------------------------------
// afcd_clip
// Clip-space transform of the eight box corners and the six plane tests.
// ----------------------------------------------------------------------------
module afcd_clip (
   input  logic                    clock,
   input  afcd_pkg::stage_en_type  en,
   input  afcd_pkg::coef_mat_type  coef,
   input  afcd_pkg::vec3_type      box_min,
   input  afcd_pkg::vec3_type      box_max,
   output logic                    outside
);
   import afcd_pkg::*;

   logic signed [PROD_W-1:0] prod_lo_in [4][3];
   logic signed [PROD_W-1:0] prod_hi_in [4][3];
   logic signed [PROD_W-1:0] prod_lo_ff [4][3];
   logic signed [PROD_W-1:0] prod_hi_ff [4][3];
   logic signed [CLIP_W-1:0] trans_in   [4];
   logic signed [CLIP_W-1:0] trans_ff   [4];
   logic signed [CLIP_W-1:0] clip_in    [8][4];
   logic signed [CLIP_W-1:0] clip_ff    [8][4];
   logic [5:0]               plane_out;

   // stage 2: one product per row, axis and box side
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_lo_in[r][c] = $signed(coef[r][c]) * $signed(box_min[c]);
            prod_hi_in[r][c] = $signed(coef[r][c]) * $signed(box_max[c]);
         end
         trans_in[r] = CLIP_W'($signed({coef[r][3], 8'h00}));
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         trans_ff   <= trans_in;
      end
   end

   // stage 3: corner sums
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         for (int r = 0; r < 4; r++) begin
            clip_in[k][r] = trans_ff[r];
            for (int c = 0; c < 3; c++) begin
               clip_in[k][r] = clip_in[k][r] + CLIP_W'(((k >> c) & 1) != 0 ?
                               prod_hi_ff[r][c] : prod_lo_ff[r][c]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         clip_ff <= clip_in;
      end
   end

   // plane tests: a plane rejects when every corner lies beyond it
   always_comb begin
      logic signed [CMP_W-1:0] lo_sum;
      logic signed [CMP_W-1:0] hi_dif;
      plane_out = 6'h3F;
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < 3; a++) begin
            lo_sum = CMP_W'(clip_ff[k][a]) + CMP_W'(clip_ff[k][3]);
            hi_dif = CMP_W'(clip_ff[k][3]) - CMP_W'(clip_ff[k][a]);
            if (!lo_sum[CMP_W-1]) plane_out[2*a] = 1'b0;
            if (!hi_dif[CMP_W-1]) plane_out[2*a+1] = 1'b0;
         end
      end
   end

   assign outside = |plane_out;

endmodule

>>> sv/afcd_dist.sv
// ----------------------------------------------------------------------------
// afcd_dist
// Squared camera distance to the box center (or origin), Q.16 rounded.
// ----------------------------------------------------------------------------
module afcd_dist (
   input  logic                        clock,
   input  afcd_pkg::stage_en_type      en,
   input  logic                        box_valid,
   input  afcd_pkg::vec3_type          box_min,
   input  afcd_pkg::vec3_type          box_max,
   input  afcd_pkg::vec3_type          origin,
   input  afcd_pkg::vec3_type          camera,
   output logic [afcd_pkg::DIST_W-1:0] dist_sq
);
   import afcd_pkg::*;

   logic signed [DELTA_W-1:0] delta [3];
   logic [SQ_W-1:0]           sq_in [3];
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SUM_W-1:0]          sum_in;
   logic [SUM_W-1:0]          sum_ff;
   logic [SUM_W-1:0]          rnd;

   // stage 2: center delta (Q.9) and its square
   always_comb begin
      logic signed [DELTA_W-1:0] c2;
      for (int a = 0; a < 3; a++) begin
         c2 = box_valid ? DELTA_W'(box_min[a]) + DELTA_W'(box_max[a])
                        : DELTA_W'(origin[a]) * DELTA_W'(2);
         delta[a] = c2 - DELTA_W'(camera[a]) * DELTA_W'(2);
         sq_in[a] = SQ_W'(SQ_W'(delta[a]) * SQ_W'(delta[a]));
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         sq_ff <= sq_in;
      end
   end

   // stage 3: sum
   assign sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         sum_ff <= sum_in;
      end
   end

   // round half up to Q.16, saturate
   assign rnd     = (sum_ff + SUM_W'(2)) >> 2;
   assign dist_sq = (rnd[SUM_W-1:DIST_W] != '0) ? {DIST_W{1'b1}} : rnd[DIST_W-1:0];

endmodule

>>> sv/aabb_frustum_cull_distance.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_distance
// Frustum cull of axis-aligned boxes with squared camera distance.
// ----------------------------------------------------------------------------
// Takes one item per clock unless back pressure stalls it. A kept item passes
// the input register, 24 coefficient products and the three distance squares,
// corner sums and distance sum, then plane tests into the output register.
// Dropped items leave a bubble and produce no beat. Back pressure stalls only
// the stages that hold data, so bubbles close up. The user must write
// configuration registers only while no item is in flight; the block does not enforce it.
`include "assert_macros.svh"

module aabb_frustum_cull_distance (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [afcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [afcd_pkg::CSR_W-1:0]       csr_wdata,
   afcd_req_if.sink                         req_ch,
   afcd_rsp_if.source                       rsp_ch
);
   import afcd_pkg::*;

   logic [CSR_W-1:0]    mat_col_ff [4];
   logic [2*CAM_BITS-1:0] cam_xy_ff;
   logic [CAM_BITS-1:0] cam_z_ff;
   logic                cull_en_ff;
   logic [CSR_W-1:0]    inv_ff;

   coef_mat_type        coef;
   vec3_type            camera;
   stage_en_type        en;

   logic adv1, adv2, adv3, adv4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic pass_in;
   logic pass1_ff, pass2_ff, pass3_ff;
   logic bv1_ff, bv2_ff, bv3_ff;
   logic [HANDLE_W-1:0] mesh1_ff, mesh2_ff, mesh3_ff, mesh4_ff;
   logic [HANDLE_W-1:0] mat1_ff, mat2_ff, mat3_ff, mat4_ff;
   vec3_type            mn1_ff, mx1_ff, org1_ff;
   logic                outside;
   logic                keep;
   logic [DIST_W-1:0]   dist_sq;
   logic [DIST_W-1:0]   dist4_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_col_ff[0] <= CSR_W'(64'h0000_0000_0000_1000);
         mat_col_ff[1] <= CSR_W'(64'h0000_0000_1000_0000);
         mat_col_ff[2] <= CSR_W'(64'h0000_1000_0000_0000);
         mat_col_ff[3] <= CSR_W'(64'h1000_0000_0000_0000);
         cam_xy_ff     <= '0;
         cam_z_ff      <= '0;
         cull_en_ff    <= 1'b1;
         inv_ff        <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MATRIX_COL0:     mat_col_ff[0] <= csr_wdata;
            REG_MATRIX_COL1:     mat_col_ff[1] <= csr_wdata;
            REG_MATRIX_COL2:     mat_col_ff[2] <= csr_wdata;
            REG_MATRIX_COL3:     mat_col_ff[3] <= csr_wdata;
            REG_CAMERA_XY:       cam_xy_ff     <= csr_wdata[2*CAM_BITS-1:0];
            REG_CAMERA_Z:        cam_z_ff      <= csr_wdata[CAM_BITS-1:0];
            REG_CULL_ENABLE:     cull_en_ff    <= csr_wdata[0];
            REG_INVALID_HANDLES: inv_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = mat_col_ff[c][SLOT_W*r +: COEF_BITS];
         end
      end
      camera[0] = cam_xy_ff[CAM_BITS-1:0];
      camera[1] = cam_xy_ff[2*CAM_BITS-1:CAM_BITS];
      camera[2] = cam_z_ff;
   end

   // stage advance
   assign adv4 = !v4_ff || rsp_ch.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ch.ready = adv1;
   assign en.s2 = adv2;
   assign en.s3 = adv3;

   assign pass_in = req_ch.item_flags[0] &&
                    (req_ch.mesh_id != inv_ff[HANDLE_W-1:0]) &&
                    (req_ch.material_id != inv_ff[2*HANDLE_W-1:HANDLE_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_ch.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         pass1_ff <= pass_in;
         bv1_ff   <= req_ch.item_flags[1];
         mesh1_ff <= req_ch.mesh_id;
         mat1_ff  <= req_ch.material_id;
         mn1_ff   <= {req_ch.box_min_z, req_ch.box_min_y, req_ch.box_min_x};
         mx1_ff   <= {req_ch.box_max_z, req_ch.box_max_y, req_ch.box_max_x};
         org1_ff  <= {req_ch.origin_z, req_ch.origin_y, req_ch.origin_x};
      end
      if (adv2) begin
         pass2_ff <= pass1_ff;
         bv2_ff   <= bv1_ff;
         mesh2_ff <= mesh1_ff;
         mat2_ff  <= mat1_ff;
      end
      if (adv3) begin
         pass3_ff <= pass2_ff;
         bv3_ff   <= bv2_ff;
         mesh3_ff <= mesh2_ff;
         mat3_ff  <= mat2_ff;
      end
      if (adv4) begin
         mesh4_ff <= mesh3_ff;
         mat4_ff  <= mat3_ff;
         dist4_ff <= dist_sq;
      end
   end

   afcd_clip u_clip (
      .clock   (clock),
      .en      (en),
      .coef    (coef),
      .box_min (mn1_ff),
      .box_max (mx1_ff),
      .outside (outside)
   );

   afcd_dist u_dist (
      .clock     (clock),
      .en        (en),
      .box_valid (bv1_ff),
      .box_min   (mn1_ff),
      .box_max   (mx1_ff),
      .origin    (org1_ff),
      .camera    (camera),
      .dist_sq   (dist_sq)
   );

   assign keep = pass3_ff && !(cull_en_ff && bv3_ff && outside);

   assign rsp_ch.valid            = v4_ff;
   assign rsp_ch.kept_mesh_id     = mesh4_ff;
   assign rsp_ch.kept_material_id = mat4_ff;
   assign rsp_ch.distance_sq      = dist4_ff;

   `AFCD_ASSERT_IMP(a_no_ready_means_full, clock, reset, !req_ch.ready, v1_ff && v2_ff && v3_ff && v4_ff)
   `AFCD_ASSERT_NXT(a_stalled_item_kept, clock, reset, v1_ff && !adv2, v1_ff)
   `AFCD_ASSERT_IMP(a_out_mesh_valid, clock, reset, rsp_ch.valid, rsp_ch.kept_mesh_id != inv_ff[HANDLE_W-1:0])

endmodule
